// ===== rtl/core/scep_pkg.sv =====
`default_nettype none

package scep_pkg;

	// coordinate width inside the block: holds any frame size register value
	localparam int unsigned COORD_W = 10;
	// width of the coordinate and result ports
	localparam int unsigned FIELD_W = 9;
	localparam int unsigned PIX_W = 32;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 10;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [CFG_DATA_W-1:0] FRAME_SIZE_RESET = 10'd512;

	// controller to datapath
	typedef struct packed {
		logic accept;       // take the item on the input ports
		logic walk_rd;      // memory read address from the walk, else from the inputs
		logic init_walk;    // latch seed color, start the rightward walk
		logic end_walk;     // close the current direction, go to the next one
		logic end_at_limit; // closing value is the frame edge, else the current position
		logic advance;      // step onto the next pixel
	} scep_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic seed_error;   // seed on the input ports lies outside the frame
		logic edge_reached; // walk is at the edge or one step before it
		logic color_match;  // pixel just read has the seed color
		logic last_dir;     // walking upward, the last direction
	} scep_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/scep_dpath.sv =====
`default_nettype none

module scep_dpath #(
	parameter int unsigned MAX_WIDTH = 512,
	parameter int unsigned MAX_HEIGHT = 512
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire scep_pkg::scep_cmd_t                cmd,
	output scep_pkg::scep_stat_t                    stat,
	input  wire logic                               operation,
	input  wire logic [scep_pkg::FIELD_W-1:0]       pixel_x,
	input  wire logic [scep_pkg::FIELD_W-1:0]       pixel_y,
	input  wire logic [scep_pkg::PIX_W-1:0]         pixel_value,
	input  wire logic                               cfg_we,
	input  wire logic [scep_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [scep_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic [scep_pkg::FIELD_W-1:0]            region_left,
	output logic [scep_pkg::FIELD_W-1:0]            region_top,
	output logic [scep_pkg::FIELD_W-1:0]            region_width,
	output logic [scep_pkg::FIELD_W-1:0]            region_height,
	output logic                                    seed_error
);
	import scep_pkg::*;

	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AW = $clog2(DEPTH);

	typedef enum logic [1:0] {DIR_RIGHT, DIR_LEFT, DIR_DOWN, DIR_UP} dir_t;

	function automatic logic [AW-1:0] pix_addr(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		return AW'(32'(y) * MAX_WIDTH + 32'(x));
	endfunction

	logic [PIX_W-1:0]      frame_mem [DEPTH];
	logic [PIX_W-1:0]      rd_data_q;
	logic [CFG_DATA_W-1:0] frame_width_q;
	logic [CFG_DATA_W-1:0] frame_height_q;
	logic [COORD_W-1:0]    seed_x_q;
	logic [COORD_W-1:0]    seed_y_q;
	logic                  err_q;
	logic [PIX_W-1:0]      color_q;
	dir_t                  dir_q;
	logic [COORD_W-1:0]    pos_q;
	logic [COORD_W-1:0]    right_q;
	logic [COORD_W-1:0]    left_q;
	logic [COORD_W-1:0]    bottom_q;
	logic [COORD_W-1:0]    top_q;

	logic [COORD_W-1:0] w_eff;
	logic [COORD_W-1:0] h_eff;
	logic [COORD_W-1:0] in_x;
	logic [COORD_W-1:0] in_y;
	logic               in_store;
	logic               mem_we;
	logic [AW-1:0]      in_addr;
	logic [AW-1:0]      walk_addr;
	logic [AW-1:0]      rd_addr;
	logic               horizontal;
	logic               forward;
	logic [COORD_W-1:0] limit;
	logic [COORD_W-1:0] next_pos;
	logic [COORD_W-1:0] end_val;

	// frame size saturates at the store size
	assign w_eff = (32'(frame_width_q) > MAX_WIDTH) ? COORD_W'(MAX_WIDTH) : frame_width_q;
	assign h_eff = (32'(frame_height_q) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT) : frame_height_q;

	assign in_x = COORD_W'(pixel_x);
	assign in_y = COORD_W'(pixel_y);
	assign in_store = (32'(pixel_x) < MAX_WIDTH) && (32'(pixel_y) < MAX_HEIGHT);
	assign mem_we = cmd.accept && (operation == OP_WRITE) && in_store;
	assign in_addr = pix_addr(in_x, in_y);

	assign horizontal = (dir_q == DIR_RIGHT) || (dir_q == DIR_LEFT);
	assign forward = (dir_q == DIR_RIGHT) || (dir_q == DIR_DOWN);
	assign next_pos = forward ? pos_q + 1'b1 : pos_q - 1'b1;

	always_comb begin
		unique case (dir_q)
			DIR_RIGHT: limit = w_eff - 1'b1;
			DIR_DOWN:  limit = h_eff - 1'b1;
			default:   limit = '0;
		endcase
	end

	assign walk_addr = horizontal ? pix_addr(next_pos, seed_y_q) : pix_addr(seed_x_q, next_pos);
	assign rd_addr = cmd.walk_rd ? walk_addr : in_addr;
	assign end_val = cmd.end_at_limit ? limit : pos_q;

	assign stat.seed_error = (in_x >= w_eff) || (in_y >= h_eff);
	assign stat.edge_reached = (pos_q == limit) || (next_pos == limit);
	assign stat.color_match = (rd_data_q == color_q);
	assign stat.last_dir = (dir_q == DIR_UP);

	// frame store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_mem[in_addr] <= pixel_value;
		end
		rd_data_q <= frame_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FRAME_SIZE_RESET;
			frame_height_q <= FRAME_SIZE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_FRAME_WIDTH) begin
				frame_width_q <= cfg_data;
			end else if (cfg_index == REG_FRAME_HEIGHT) begin
				frame_height_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && (operation == OP_QUERY)) begin
			seed_x_q <= in_x;
			seed_y_q <= in_y;
			err_q <= stat.seed_error;
		end
		if (cmd.init_walk) begin
			color_q <= rd_data_q;
			dir_q <= DIR_RIGHT;
			pos_q <= seed_x_q;
		end else if (cmd.end_walk) begin
			unique case (dir_q)
				DIR_RIGHT: right_q <= end_val;
				DIR_LEFT:  left_q <= end_val;
				DIR_DOWN:  bottom_q <= end_val;
				DIR_UP:    top_q <= end_val;
			endcase
			dir_q <= dir_t'(dir_q + 2'd1);
			// after right comes left (a row), after that down and up (a column)
			pos_q <= (dir_q == DIR_RIGHT) ? seed_x_q : seed_y_q;
		end else if (cmd.advance) begin
			pos_q <= next_pos;
		end
	end

	assign region_left = err_q ? '0 : left_q[FIELD_W-1:0];
	assign region_top = err_q ? '0 : top_q[FIELD_W-1:0];
	assign region_width = err_q ? '0 : FIELD_W'(right_q - left_q);
	assign region_height = err_q ? '0 : FIELD_W'(bottom_q - top_q);
	assign seed_error = err_q;

endmodule

`default_nettype wire

// ===== rtl/core/scep_ctrl.sv =====
`default_nettype none

module scep_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 operation,
	input  wire scep_pkg::scep_stat_t stat,
	output scep_pkg::scep_cmd_t       cmd,
	output logic                      busy,
	output logic                      done
);
	import scep_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_COLOR, ST_STEP, ST_CHECK} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   accept;
	logic   walk_over;

	assign accept = start && !busy_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:  cmd.accept = accept;
			ST_COLOR: cmd.init_walk = 1'b1;
			ST_STEP: begin
				cmd.walk_rd = 1'b1;
				cmd.end_walk = stat.edge_reached;
				cmd.end_at_limit = 1'b1;
			end
			ST_CHECK: begin
				cmd.advance = stat.color_match;
				cmd.end_walk = !stat.color_match;
			end
		endcase
	end

	assign walk_over = cmd.end_walk && stat.last_dir;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (operation == OP_QUERY)) begin
						if (stat.seed_error) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_COLOR;
							busy_q <= 1'b1;
						end
					end
				end
				ST_COLOR: state_q <= ST_STEP;
				ST_STEP: begin
					if (walk_over) begin
						state_q <= ST_IDLE;
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else if (!stat.edge_reached) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (walk_over) begin
						state_q <= ST_IDLE;
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						state_q <= ST_STEP;
					end
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ===== rtl/core/same_color_extent_probe_top.sv =====
// same-color extent probe: holds a frame of 32-bit color words and measures
// the run of seed-colored pixels through a seed point along its row and column
// request channel: start/busy; a request is taken at a clock edge with start
// high and busy low. operation selects a pixel write or an extent query
// pixel writes never raise busy and give no result, so a capture stream can
// load one pixel every cycle while no query holds busy high
// a query with the seed inside the frame raises busy; the seed color is read,
// then the walk goes right, left, down and up, reading each compared pixel
// on the single memory read port; a direction ends at the frame edge or at
// the first pixel without the seed color. a seed outside the frame gives
// its result, with seed_error, in the cycle after the request
// the result is shown for exactly one cycle with done high; the receiver
// takes it then and cannot stall it. busy is already low during that cycle
// configuration: cfg_valid/cfg_ready write channel, always ready; write only
// while no query is in flight
// reset brings both frame size registers to 512 and the controller to idle;
// frame store contents are undefined until written
`default_nettype none

module same_color_extent_probe_top #(
	parameter int unsigned MAX_WIDTH = 512,
	parameter int unsigned MAX_HEIGHT = 512
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// request channel
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic                               operation,
	input  wire logic [scep_pkg::FIELD_W-1:0]       pixel_x,
	input  wire logic [scep_pkg::FIELD_W-1:0]       pixel_y,
	input  wire logic [scep_pkg::PIX_W-1:0]         pixel_value,
	// result, valid for one cycle with done
	output logic                                    done,
	output logic [scep_pkg::FIELD_W-1:0]            region_left,
	output logic [scep_pkg::FIELD_W-1:0]            region_top,
	output logic [scep_pkg::FIELD_W-1:0]            region_width,
	output logic [scep_pkg::FIELD_W-1:0]            region_height,
	output logic                                    seed_error,
	// configuration write channel
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [scep_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [scep_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import scep_pkg::*;

	scep_cmd_t  cmd;
	scep_stat_t stat;

	// registers can be written at any cycle
	assign cfg_ready = 1'b1;

	// sequencer: idle, seed color, then step/check per compared pixel
	scep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	// frame store, frame size registers, walk position and result registers
	scep_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.operation     (operation),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_value   (pixel_value),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.region_left   (region_left),
		.region_top    (region_top),
		.region_width  (region_width),
		.region_height (region_height),
		.seed_error    (seed_error)
	);

	// a result always comes with the controller back at idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a query is still walking");

	// pixel writes never produce a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == OP_WRITE)) |=> !done)
		else $error("result after a pixel write");

	// seed outside the frame answers on the next cycle with the error flag
	a_seed_err: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == OP_QUERY) && stat.seed_error)
		|=> (done && seed_error && !busy))
		else $error("seed outside frame not reported at once");

	// busy only rises after a query request
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && (operation == OP_QUERY)))
		else $error("busy rose without a query request");

endmodule

`default_nettype wire
